// ===== src/vsie_pkg.sv =====
// Package for the virtual-8086 sensitive instruction emulator.
// Holds phase, request codes, context and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vsie_pkg;

    localparam logic [3:0] MAX_PREFIXES = 4'd15;
    localparam logic [31:0] FORCE_ON = 32'h0002_0200;
    localparam logic [31:0] IF_BIT = 32'h0000_0200;
    localparam logic [7:0] EXIT_VECTOR_RESET = 8'd128;

    localparam logic [7:0] OP_INT = 8'hcd;
    localparam logic [7:0] OP_IRET = 8'hcf;
    localparam logic [7:0] OP_POPF = 8'h9d;
    localparam logic [7:0] OP_PUSHF = 8'h9c;
    localparam logic [7:0] OP_STI = 8'hfb;
    localparam logic [7:0] OP_CLI = 8'hfa;
    localparam logic [7:0] OP_OUTB = 8'hee;
    localparam logic [7:0] OP_OUTW = 8'hef;
    localparam logic [7:0] OP_INB = 8'hec;
    localparam logic [7:0] OP_INW = 8'hed;
    localparam logic [7:0] OP_OPSIZE = 8'h66;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FETCH, PH_INTNUM, PH_VECTOR, PH_POP, PH_PORTIN
    } t_phase;

    typedef enum logic [3:0] {
        REQ_FETCH, REQ_RD16, REQ_RD32, REQ_RD48, REQ_WR16, REQ_WR32,
        REQ_IN8, REQ_IN16, REQ_IN32, REQ_OUT8, REQ_OUT16, REQ_OUT32,
        REQ_RESUME, REQ_EXIT, REQ_UNIMPL, REQ_PFX_OVF
    } t_req;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] cs;
        logic [15:0] ip;
        logic [15:0] ss;
        logic [15:0] sp;
        logic [31:0] flags;
        logic [31:0] eax;
        logic [15:0] port;
        logic        vif;
        logic        op32;
        logic [3:0]  pcnt;
        logic [7:0]  opcode;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] code_seg;
        logic [15:0] instr_off;
        logic [15:0] stack_seg;
        logic [15:0] stack_off;
        logic [31:0] flags_in;
        logic [31:0] accum_in;
        logic [15:0] port_num;
        logic        vif_in;
        logic [47:0] resp_data;
    } t_in;

    typedef struct packed {
        logic [3:0]  req;
        logic [20:0] addr;
        logic [31:0] wdata;
        logic [15:0] cs_out;
        logic [15:0] ip_out;
        logic [15:0] sp_out;
        logic [31:0] flags_out;
        logic [31:0] accum_out;
        logic        vif_out;
        logic        last;
    } t_result;

    function automatic logic [20:0] lin(input logic [15:0] seg, input logic [15:0] off);
        return {1'b0, seg, 4'b0} + {5'b0, off};
    endfunction

    function automatic logic is_prefix(input logic [7:0] b);
        return b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
               b == 8'h64 || b == 8'h65 || b == 8'h66 || b == 8'h67 ||
               b == 8'hf0 || b == 8'hf2 || b == 8'hf3;
    endfunction

endpackage
`default_nettype wire

// ===== src/vsie_if.sv =====
// Valid/ready channel interfaces for input beats and result beats.
// Payload widths match vsie_pkg, but the interfaces do not import it.
`timescale 1ns / 1ps
`default_nettype none
interface vsie_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] code_seg;
    logic [15:0] instr_off;
    logic [15:0] stack_seg;
    logic [15:0] stack_off;
    logic [31:0] flags_in;
    logic [31:0] accum_in;
    logic [15:0] port_num;
    logic        vif_in;
    logic [47:0] resp_data;
    modport source (output valid, kind, code_seg, instr_off, stack_seg, stack_off,
                    flags_in, accum_in, port_num, vif_in, resp_data, input ready);
    modport sink (input valid, kind, code_seg, instr_off, stack_seg, stack_off,
                  flags_in, accum_in, port_num, vif_in, resp_data, output ready);
endinterface

interface vsie_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req;
    logic [20:0] addr;
    logic [31:0] wdata;
    logic [15:0] cs_out;
    logic [15:0] ip_out;
    logic [15:0] sp_out;
    logic [31:0] flags_out;
    logic [31:0] accum_out;
    logic        vif_out;
    logic        last;
    modport source (output valid, req, addr, wdata, cs_out, ip_out, sp_out, flags_out,
                    accum_out, vif_out, last, input ready);
    modport sink (input valid, req, addr, wdata, cs_out, ip_out, sp_out, flags_out,
                  accum_out, vif_out, last, output ready);
endinterface
`default_nettype wire

// ===== src/vsie_step.sv =====
// Decode step: from the context state and one input beat, the next state
// and up to four result beats. Depends on vsie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsie_step
    import vsie_pkg::*;
(
    input  wire t_state        i_st,
    input  wire t_in           i_beat,
    input  wire logic [7:0]    i_exit_vector,
    output t_state             o_st,
    output t_result [3:0]      o_res,
    output logic [2:0]         o_cnt
);

    logic        done;
    logic [1:0]  done_idx;
    t_req        done_code;
    logic [31:0] lo;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [7:0]  b;
    logic [31:0] vflags;
    logic [15:0] ip1;
    logic [15:0] nsp;
    logic [31:0] pv;

    function automatic t_result mkreq(input t_req r, input logic [20:0] a,
                                      input logic [31:0] d, input logic l);
        t_result x;
        x = '0;
        x.req = r;
        x.addr = a;
        x.wdata = d;
        x.last = l;
        return x;
    endfunction

    always_comb begin
        lo = i_beat.resp_data[31:0];
        w0 = lo[15:0];
        w1 = lo[31:16];
        w2 = i_beat.resp_data[47:32];
        b = lo[7:0];
        vflags = i_st.vif ? (i_st.flags | IF_BIT) : (i_st.flags & ~IF_BIT);
        ip1 = i_st.ip + 16'd1;
        nsp = '0;
        pv = '0;
        o_st = i_st;
        o_res = '0;
        o_cnt = 3'd0;
        done = 1'b0;
        done_idx = 2'd0;
        done_code = REQ_RESUME;
        if (!i_beat.kind) begin
            o_st.cs = i_beat.code_seg;
            o_st.ip = i_beat.instr_off;
            o_st.ss = i_beat.stack_seg;
            o_st.sp = i_beat.stack_off;
            o_st.flags = i_beat.flags_in;
            o_st.eax = i_beat.accum_in;
            o_st.port = i_beat.port_num;
            o_st.vif = i_beat.vif_in;
            o_st.op32 = 1'b0;
            o_st.pcnt = '0;
            o_st.opcode = '0;
            o_st.phase = PH_FETCH;
            o_res[0] = mkreq(REQ_FETCH, lin(i_beat.code_seg, i_beat.instr_off), '0, 1'b1);
            o_cnt = 3'd1;
        end else begin
            case (i_st.phase)
                PH_FETCH: begin
                    if (is_prefix(b)) begin
                        if (i_st.pcnt >= MAX_PREFIXES) begin
                            done = 1'b1;
                            done_code = REQ_PFX_OVF;
                        end else begin
                            o_st.pcnt = i_st.pcnt + 4'd1;
                            if (b == OP_OPSIZE) begin
                                o_st.op32 = 1'b1;
                            end
                            o_st.ip = ip1;
                            o_res[0] = mkreq(REQ_FETCH, lin(i_st.cs, ip1), '0, 1'b1);
                            o_cnt = 3'd1;
                        end
                    end else begin
                        o_st.opcode = b;
                        case (b)
                            OP_INT: begin
                                o_st.phase = PH_INTNUM;
                                o_res[0] = mkreq(REQ_FETCH, lin(i_st.cs, ip1), '0, 1'b1);
                                o_cnt = 3'd1;
                            end
                            OP_IRET: begin
                                o_st.phase = PH_POP;
                                o_res[0] = mkreq(REQ_RD48, lin(i_st.ss, i_st.sp), '0, 1'b1);
                                o_cnt = 3'd1;
                            end
                            OP_POPF: begin
                                o_st.phase = PH_POP;
                                o_res[0] = mkreq(i_st.op32 ? REQ_RD32 : REQ_RD16,
                                                 lin(i_st.ss, i_st.sp), '0, 1'b1);
                                o_cnt = 3'd1;
                            end
                            OP_PUSHF: begin
                                if (i_st.op32) begin
                                    nsp = i_st.sp - 16'd4;
                                    o_res[0] = mkreq(REQ_WR32, lin(i_st.ss, nsp), vflags, 1'b0);
                                end else begin
                                    nsp = i_st.sp - 16'd2;
                                    o_res[0] = mkreq(REQ_WR16, lin(i_st.ss, nsp),
                                                     {16'b0, vflags[15:0]}, 1'b0);
                                end
                                o_st.sp = nsp;
                                o_st.ip = ip1;
                                done = 1'b1;
                                done_idx = 2'd1;
                            end
                            OP_STI, OP_CLI: begin
                                o_st.vif = (b == OP_STI);
                                o_st.ip = ip1;
                                done = 1'b1;
                            end
                            OP_OUTB: begin
                                o_res[0] = mkreq(REQ_OUT8, {5'b0, i_st.port},
                                                 {24'b0, i_st.eax[7:0]}, 1'b0);
                                o_st.ip = ip1;
                                done = 1'b1;
                                done_idx = 2'd1;
                            end
                            OP_OUTW: begin
                                if (i_st.op32) begin
                                    o_res[0] = mkreq(REQ_OUT32, {5'b0, i_st.port},
                                                     i_st.eax, 1'b0);
                                end else begin
                                    o_res[0] = mkreq(REQ_OUT16, {5'b0, i_st.port},
                                                     {16'b0, i_st.eax[15:0]}, 1'b0);
                                end
                                o_st.ip = ip1;
                                done = 1'b1;
                                done_idx = 2'd1;
                            end
                            OP_INB: begin
                                o_st.phase = PH_PORTIN;
                                o_res[0] = mkreq(REQ_IN8, {5'b0, i_st.port}, '0, 1'b1);
                                o_cnt = 3'd1;
                            end
                            OP_INW: begin
                                o_st.phase = PH_PORTIN;
                                o_res[0] = mkreq(i_st.op32 ? REQ_IN32 : REQ_IN16,
                                                 {5'b0, i_st.port}, '0, 1'b1);
                                o_cnt = 3'd1;
                            end
                            default: begin
                                done = 1'b1;
                                done_code = REQ_UNIMPL;
                            end
                        endcase
                    end
                end
                PH_INTNUM: begin
                    if (b == i_exit_vector) begin
                        done = 1'b1;
                        done_code = REQ_EXIT;
                    end else begin
                        o_res[0] = mkreq(REQ_WR16, lin(i_st.ss, i_st.sp - 16'd2),
                                         {16'b0, vflags[15:0]}, 1'b0);
                        o_res[1] = mkreq(REQ_WR16, lin(i_st.ss, i_st.sp - 16'd4),
                                         {16'b0, i_st.cs}, 1'b0);
                        o_res[2] = mkreq(REQ_WR16, lin(i_st.ss, i_st.sp - 16'd6),
                                         {16'b0, i_st.ip + 16'd2}, 1'b0);
                        o_res[3] = mkreq(REQ_RD32, {11'b0, b, 2'b0}, '0, 1'b1);
                        o_cnt = 3'd4;
                        o_st.sp = i_st.sp - 16'd6;
                        o_st.vif = 1'b0;
                        o_st.phase = PH_VECTOR;
                    end
                end
                PH_VECTOR: begin
                    o_st.ip = w0;
                    o_st.cs = w1;
                    done = 1'b1;
                end
                PH_POP: begin
                    if (i_st.opcode == OP_IRET) begin
                        o_st.ip = w0;
                        o_st.cs = w1;
                        o_st.vif = w2[9];
                        o_st.flags = {16'b0, w2} | FORCE_ON;
                        o_st.sp = i_st.sp + 16'd6;
                    end else begin
                        pv = i_st.op32 ? lo : {16'b0, w0};
                        o_st.vif = pv[9];
                        o_st.flags = pv | FORCE_ON;
                        o_st.sp = i_st.sp + (i_st.op32 ? 16'd4 : 16'd2);
                        o_st.ip = ip1;
                    end
                    done = 1'b1;
                end
                PH_PORTIN: begin
                    if (i_st.opcode == OP_INB) begin
                        o_st.eax = {i_st.eax[31:8], lo[7:0]};
                    end else if (i_st.op32) begin
                        o_st.eax = lo;
                    end else begin
                        o_st.eax = {i_st.eax[31:16], w0};
                    end
                    o_st.ip = ip1;
                    done = 1'b1;
                end
                default: begin
                    o_st.phase = PH_IDLE;
                end
            endcase
        end
        if (done) begin
            o_res[done_idx] = '0;
            o_res[done_idx].req = done_code;
            o_res[done_idx].cs_out = o_st.cs;
            o_res[done_idx].ip_out = o_st.ip;
            o_res[done_idx].sp_out = o_st.sp;
            o_res[done_idx].flags_out = o_st.flags;
            o_res[done_idx].accum_out = o_st.eax;
            o_res[done_idx].vif_out = o_st.vif;
            o_res[done_idx].last = 1'b1;
            o_cnt = {1'b0, done_idx} + 3'd1;
            o_st.phase = PH_IDLE;
        end
    end

endmodule
`default_nettype wire

// ===== src/v86_sensitive_instruction_emulator.sv =====
// Virtual-8086 sensitive instruction emulator, top level.
// The first result beat of an input beat is offered in the cycle after acceptance.
// One input beat per cycle while each yields one result and the output is ready;
// a beat's k results fill k of the four buffer entries; the next beat waits on them.
// Reset: synchronous active-low; clears phase, context, buffer count, exit vector to 128.
// Depends on vsie_pkg, vsie_if and vsie_step.
`timescale 1ns / 1ps
`default_nettype none
module v86_sensitive_instruction_emulator
    import vsie_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vsie_in_if.sink     i_in,
    vsie_out_if.source  o_out,
    input  wire logic   i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);

    t_state          r_st;
    t_state          n_st;
    logic [7:0]      r_exit_vector;
    t_result [3:0]   r_buf;
    t_result [3:0]   step_res;
    logic [2:0]      r_cnt;
    logic [2:0]      step_cnt;
    t_in             beat;
    logic            in_fire;
    logic            out_fire;

    assign beat = '{kind: i_in.kind, code_seg: i_in.code_seg, instr_off: i_in.instr_off,
                    stack_seg: i_in.stack_seg, stack_off: i_in.stack_off,
                    flags_in: i_in.flags_in, accum_in: i_in.accum_in,
                    port_num: i_in.port_num, vif_in: i_in.vif_in,
                    resp_data: i_in.resp_data};

    vsie_step u_step (
        .i_st          (r_st),
        .i_beat        (beat),
        .i_exit_vector (r_exit_vector),
        .o_st          (n_st),
        .o_res         (step_res),
        .o_cnt         (step_cnt)
    );

    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_cnt <= '0;
            r_exit_vector <= EXIT_VECTOR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_exit_vector <= i_cfg_data;
            end
            if (in_fire) begin
                r_st <= n_st;
                r_cnt <= step_cnt;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf <= step_res;
        end else if (out_fire) begin
            r_buf <= {t_result'('0), r_buf[3:1]};
        end
    end

    assign o_out.valid = (r_cnt != 3'd0);
    assign o_out.req = r_buf[0].req;
    assign o_out.addr = r_buf[0].addr;
    assign o_out.wdata = r_buf[0].wdata;
    assign o_out.cs_out = r_buf[0].cs_out;
    assign o_out.ip_out = r_buf[0].ip_out;
    assign o_out.sp_out = r_buf[0].sp_out;
    assign o_out.flags_out = r_buf[0].flags_out;
    assign o_out.accum_out = r_buf[0].accum_out;
    assign o_out.vif_out = r_buf[0].vif_out;
    assign o_out.last = r_buf[0].last;

endmodule
`default_nettype wire
